/* rtl/qsort_pkg.sv */
// Shared types, constants and helpers for the quicksort sorter.
// No dependencies; qsort_ctrl, quicksort_sorter_top and qsort_checker import it.
package qsort_pkg;

    localparam int QS_MAX_ITEMS   = 64;
    localparam int QS_VALUE_WIDTH = 32;

    typedef struct packed {
        logic signed [QS_VALUE_WIDTH-1:0] value;
        logic                             last;
    } item_t;

    typedef struct packed {
        logic signed [QS_VALUE_WIDTH-1:0] sorted_value;
        logic                             end_of_run;
        logic                             overflow;
    } result_t;

    // Load request from the sequencer into the output register.
    typedef struct packed {
        logic    load;
        result_t data;
    } emit_t;

    typedef enum logic [3:0] {
        ST_COLLECT,
        ST_POP,
        ST_POP_WAIT,
        ST_PIVOT,
        ST_SCAN_I,
        ST_SCAN_J,
        ST_CHECK,
        ST_SWAP_I,
        ST_SWAP_J,
        ST_FINAL_LO,
        ST_FINAL_J,
        ST_PUSH_L,
        ST_EMIT_RD,
        ST_EMIT_LD,
        ST_EMIT_WAIT
    } qsort_state_t;

    function automatic logic less_than(input logic [QS_VALUE_WIDTH-1:0] a,
                                       input logic [QS_VALUE_WIDTH-1:0] b);
        return $signed(a) < $signed(b);
    endfunction

endpackage

/* rtl/quicksort_sorter_top.sv */
// Quicksort sorter, top level: element RAM, range-stack RAM, sequencer and
// output register. Depends on qsort_pkg, qsort_ram and qsort_ctrl.
//
// Values are taken one per cycle while collecting; up to MAX_ITEMS are kept
// and the rest are dropped (overflow is then set on every result of the run).
// The transaction marked last starts the sort; input stays stalled until
// the final sorted result has been taken. The sort is an in-place quicksort
// over a single-port-read element RAM: a range is popped from the stack and
// its pivot read (ST_POP, ST_POP_WAIT, ST_PIVOT), the two pointers then scan
// the range, each swap passes ST_CHECK, ST_SWAP_I and ST_SWAP_J, and a
// partition is closed by ST_FINAL_LO, ST_FINAL_J and ST_PUSH_L. Already
// ordered data is the slowest case. Read-out reads each result from the
// element RAM into the output register and holds it while the output stalls.
module quicksort_sorter_top
    import qsort_pkg::*;
#(
    parameter int MAX_ITEMS = QS_MAX_ITEMS
) (
    input  logic    clk,
    input  logic    rst_n,
    input  logic    item_valid,
    output logic    item_stall,
    input  item_t   item,
    output logic    result_valid,
    input  logic    result_stall,
    output result_t result
);

    localparam int AW = $clog2(MAX_ITEMS);

    logic                      s_we, s_re;
    logic [AW-1:0]             s_waddr, s_raddr;
    logic [QS_VALUE_WIDTH-1:0] s_wdata, s_rdata;
    logic                      t_we, t_re;
    logic [AW-1:0]             t_waddr, t_raddr;
    logic [2*AW-1:0]           t_wdata, t_rdata;

    emit_t   emit;
    logic    taken;
    logic    result_valid_reg, result_valid_next;
    result_t result_reg;

    qsort_ram #(
        .WIDTH (QS_VALUE_WIDTH),
        .DEPTH (MAX_ITEMS)
    ) u_store (
        .clk   (clk),
        .we    (s_we),
        .waddr (s_waddr),
        .wdata (s_wdata),
        .re    (s_re),
        .raddr (s_raddr),
        .rdata (s_rdata)
    );

    qsort_ram #(
        .WIDTH (2*AW),
        .DEPTH (MAX_ITEMS)
    ) u_stack (
        .clk   (clk),
        .we    (t_we),
        .waddr (t_waddr),
        .wdata (t_wdata),
        .re    (t_re),
        .raddr (t_raddr),
        .rdata (t_rdata)
    );

    qsort_ctrl #(
        .MAX_ITEMS (MAX_ITEMS)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item       (item),
        .item_stall (item_stall),
        .taken      (taken),
        .emit       (emit),
        .s_we       (s_we),
        .s_waddr    (s_waddr),
        .s_wdata    (s_wdata),
        .s_re       (s_re),
        .s_raddr    (s_raddr),
        .s_rdata    (s_rdata),
        .t_we       (t_we),
        .t_waddr    (t_waddr),
        .t_wdata    (t_wdata),
        .t_re       (t_re),
        .t_raddr    (t_raddr),
        .t_rdata    (t_rdata)
    );

    // output register
    assign taken = result_valid_reg && !result_stall;

    always_comb
    begin
        if (emit.load)
        begin
            result_valid_next = 1'b1;
        end
        else if (taken)
        begin
            result_valid_next = 1'b0;
        end
        else
        begin
            result_valid_next = result_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else
        begin
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit.load)
        begin
            result_reg <= emit.data;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule

/* rtl/qsort_ram.sv */
// Single-port-write, single-port-read synchronous RAM with registered read data.
// Same-cycle write to the read address is forwarded. Depends on nothing.
module qsort_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            if (we && (waddr == raddr))
            begin
                rdata_reg <= wdata;
            end
            else
            begin
                rdata_reg <= mem[raddr];
            end
        end
    end

    assign rdata = rdata_reg;

endmodule

/* rtl/qsort_ctrl.sv */
// Sequencer and datapath: collect, Hoare partition over the element RAM,
// range stack handling, and read-out. Depends on qsort_pkg.
module qsort_ctrl
    import qsort_pkg::*;
#(
    parameter int MAX_ITEMS = QS_MAX_ITEMS
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         item_valid,
    input  item_t                        item,
    output logic                         item_stall,
    input  logic                         taken,
    output emit_t                        emit,
    // element store
    output logic                         s_we,
    output logic [$clog2(MAX_ITEMS)-1:0] s_waddr,
    output logic [QS_VALUE_WIDTH-1:0]    s_wdata,
    output logic                         s_re,
    output logic [$clog2(MAX_ITEMS)-1:0] s_raddr,
    input  logic [QS_VALUE_WIDTH-1:0]    s_rdata,
    // range stack
    output logic                         t_we,
    output logic [$clog2(MAX_ITEMS)-1:0] t_waddr,
    output logic [2*$clog2(MAX_ITEMS)-1:0] t_wdata,
    output logic                         t_re,
    output logic [$clog2(MAX_ITEMS)-1:0] t_raddr,
    input  logic [2*$clog2(MAX_ITEMS)-1:0] t_rdata
);

    localparam int AW = $clog2(MAX_ITEMS);
    localparam int CW = AW + 1;

    localparam logic [CW-1:0] MAX_C = CW'(MAX_ITEMS);
    localparam logic [CW-1:0] ONE_C = CW'(1);
    localparam logic [CW-1:0] TWO_C = CW'(2);

    qsort_state_t state_reg, state_next;

    logic [CW-1:0]             count_reg, count_next;
    logic                      dropped_reg, dropped_next;
    logic [CW-1:0]             sp_reg, sp_next;
    logic [CW-1:0]             k_reg, k_next;
    logic [AW-1:0]             lo_reg, lo_next;
    logic [AW-1:0]             hi_reg, hi_next;
    logic [CW-1:0]             i_reg, i_next;
    logic [CW-1:0]             j_reg, j_next;
    logic [QS_VALUE_WIDTH-1:0] pivot_reg, pivot_next;
    logic [QS_VALUE_WIDTH-1:0] vi_reg, vi_next;
    logic [QS_VALUE_WIDTH-1:0] vj_reg, vj_next;

    logic          item_take;
    logic          count_full;
    logic [CW-1:0] count_after;
    logic [CW-1:0] top_hi;
    logic [CW-1:0] lo_c, hi_c;
    logic [CW-1:0] i_inc, j_dec, j_inc, sp_dec;
    logic          i_inc_ok, j_dec_ok;
    logic          rd_lt_pivot, pivot_lt_rd;
    logic [AW-1:0] t_lo, t_hi;

    assign item_take   = item_valid && (state_reg == ST_COLLECT);
    assign count_full  = (count_reg >= MAX_C);
    assign count_after = count_full ? count_reg : count_reg + ONE_C;
    assign top_hi      = count_after - ONE_C;
    assign lo_c        = {1'b0, lo_reg};
    assign hi_c        = {1'b0, hi_reg};
    assign i_inc       = i_reg + ONE_C;
    assign j_dec       = j_reg - ONE_C;
    assign j_inc       = j_reg + ONE_C;
    assign sp_dec      = sp_reg - ONE_C;
    assign i_inc_ok    = (i_inc <= hi_c);
    assign j_dec_ok    = (j_dec > lo_c);
    assign rd_lt_pivot = less_than(s_rdata, pivot_reg);
    assign pivot_lt_rd = less_than(pivot_reg, s_rdata);
    assign t_lo        = t_rdata[2*AW-1:AW];
    assign t_hi        = t_rdata[AW-1:0];

    assign item_stall  = (state_reg != ST_COLLECT);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_COLLECT;
            count_reg   <= '0;
            dropped_reg <= 1'b0;
            sp_reg      <= '0;
            k_reg       <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            dropped_reg <= dropped_next;
            sp_reg      <= sp_next;
            k_reg       <= k_next;
        end
    end

    always_ff @(posedge clk)
    begin
        lo_reg    <= lo_next;
        hi_reg    <= hi_next;
        i_reg     <= i_next;
        j_reg     <= j_next;
        pivot_reg <= pivot_next;
        vi_reg    <= vi_next;
        vj_reg    <= vj_next;
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_COLLECT:
            begin
                if (item_take && item.last)
                begin
                    state_next = (count_after >= TWO_C) ? ST_POP : ST_EMIT_RD;
                end
            end
            ST_POP:
            begin
                state_next = (sp_reg == '0) ? ST_EMIT_RD : ST_POP_WAIT;
            end
            ST_POP_WAIT:
            begin
                state_next = (t_lo >= t_hi) ? ST_POP : ST_PIVOT;
            end
            ST_PIVOT:
            begin
                state_next = ST_SCAN_I;
            end
            ST_SCAN_I:
            begin
                if (rd_lt_pivot && i_inc_ok)
                begin
                    state_next = ST_SCAN_I;
                end
                else
                begin
                    state_next = j_dec_ok ? ST_SCAN_J : ST_CHECK;
                end
            end
            ST_SCAN_J:
            begin
                state_next = (pivot_lt_rd && j_dec_ok) ? ST_SCAN_J : ST_CHECK;
            end
            ST_CHECK:
            begin
                state_next = (i_reg >= j_reg) ? ST_FINAL_LO : ST_SWAP_I;
            end
            ST_SWAP_I:
            begin
                state_next = ST_SWAP_J;
            end
            ST_SWAP_J:
            begin
                if (i_inc_ok)
                begin
                    state_next = ST_SCAN_I;
                end
                else
                begin
                    state_next = j_dec_ok ? ST_SCAN_J : ST_CHECK;
                end
            end
            ST_FINAL_LO:
            begin
                state_next = ST_FINAL_J;
            end
            ST_FINAL_J:
            begin
                state_next = ST_PUSH_L;
            end
            ST_PUSH_L:
            begin
                state_next = ST_POP;
            end
            ST_EMIT_RD:
            begin
                state_next = ST_EMIT_LD;
            end
            ST_EMIT_LD:
            begin
                state_next = ST_EMIT_WAIT;
            end
            ST_EMIT_WAIT:
            begin
                if (taken)
                begin
                    state_next = (k_reg == count_reg) ? ST_COLLECT : ST_EMIT_LD;
                end
            end
            default:
            begin
                state_next = ST_COLLECT;
            end
        endcase
    end

    // outputs and datapath
    always_comb
    begin
        count_next   = count_reg;
        dropped_next = dropped_reg;
        sp_next      = sp_reg;
        k_next       = k_reg;
        lo_next      = lo_reg;
        hi_next      = hi_reg;
        i_next       = i_reg;
        j_next       = j_reg;
        pivot_next   = pivot_reg;
        vi_next      = vi_reg;
        vj_next      = vj_reg;
        s_we         = 1'b0;
        s_waddr      = '0;
        s_wdata      = '0;
        s_re         = 1'b0;
        s_raddr      = '0;
        t_we         = 1'b0;
        t_waddr      = '0;
        t_wdata      = '0;
        t_re         = 1'b0;
        t_raddr      = '0;
        emit         = '0;

        case (state_reg)
            ST_COLLECT:
            begin
                if (item_take)
                begin
                    if (!count_full)
                    begin
                        s_we       = 1'b1;
                        s_waddr    = count_reg[AW-1:0];
                        s_wdata    = item.value;
                        count_next = count_reg + ONE_C;
                    end
                    else
                    begin
                        dropped_next = 1'b1;
                    end
                    if (item.last)
                    begin
                        k_next  = '0;
                        sp_next = '0;
                        if (count_after >= TWO_C)
                        begin
                            t_we    = 1'b1;
                            t_waddr = '0;
                            t_wdata = {{AW{1'b0}}, top_hi[AW-1:0]};
                            sp_next = ONE_C;
                        end
                    end
                end
            end
            ST_POP:
            begin
                if (sp_reg != '0)
                begin
                    sp_next = sp_dec;
                    t_re    = 1'b1;
                    t_raddr = sp_dec[AW-1:0];
                end
            end
            ST_POP_WAIT:
            begin
                lo_next = t_lo;
                hi_next = t_hi;
                if (t_lo < t_hi)
                begin
                    s_re    = 1'b1;
                    s_raddr = t_lo;
                    i_next  = {1'b0, t_lo};
                    j_next  = {1'b0, t_hi} + ONE_C;
                end
            end
            ST_PIVOT:
            begin
                pivot_next = s_rdata;
                s_re       = 1'b1;
                s_raddr    = i_inc[AW-1:0];
                i_next     = i_inc;
            end
            ST_SCAN_I:
            begin
                if (rd_lt_pivot && i_inc_ok)
                begin
                    i_next  = i_inc;
                    s_re    = 1'b1;
                    s_raddr = i_inc[AW-1:0];
                end
                else
                begin
                    if (rd_lt_pivot)
                    begin
                        i_next = i_inc;   // ran past hi
                    end
                    else
                    begin
                        vi_next = s_rdata;
                    end
                    j_next = j_dec;
                    if (j_dec_ok)
                    begin
                        s_re    = 1'b1;
                        s_raddr = j_dec[AW-1:0];
                    end
                    else
                    begin
                        vj_next = pivot_reg;   // j landed on lo
                    end
                end
            end
            ST_SCAN_J:
            begin
                if (pivot_lt_rd)
                begin
                    j_next = j_dec;
                    if (j_dec_ok)
                    begin
                        s_re    = 1'b1;
                        s_raddr = j_dec[AW-1:0];
                    end
                    else
                    begin
                        vj_next = pivot_reg;
                    end
                end
                else
                begin
                    vj_next = s_rdata;
                end
            end
            ST_CHECK:
            begin
            end
            ST_SWAP_I:
            begin
                s_we    = 1'b1;
                s_waddr = i_reg[AW-1:0];
                s_wdata = vj_reg;
            end
            ST_SWAP_J:
            begin
                // read of i+1 may hit j; the RAM forwards the write
                s_we    = 1'b1;
                s_waddr = j_reg[AW-1:0];
                s_wdata = vi_reg;
                i_next  = i_inc;
                if (i_inc_ok)
                begin
                    s_re    = 1'b1;
                    s_raddr = i_inc[AW-1:0];
                end
                else
                begin
                    j_next = j_dec;
                    if (j_dec_ok)
                    begin
                        s_re    = 1'b1;
                        s_raddr = j_dec[AW-1:0];
                    end
                    else
                    begin
                        vj_next = pivot_reg;
                    end
                end
            end
            ST_FINAL_LO:
            begin
                s_we    = 1'b1;
                s_waddr = lo_reg;
                s_wdata = vj_reg;
            end
            ST_FINAL_J:
            begin
                s_we    = 1'b1;
                s_waddr = j_reg[AW-1:0];
                s_wdata = pivot_reg;
                if (j_inc < hi_c)
                begin
                    t_we    = 1'b1;
                    t_waddr = sp_reg[AW-1:0];
                    t_wdata = {j_inc[AW-1:0], hi_reg};
                    sp_next = sp_reg + ONE_C;
                end
            end
            ST_PUSH_L:
            begin
                if (j_reg > lo_c + ONE_C)
                begin
                    t_we    = 1'b1;
                    t_waddr = sp_reg[AW-1:0];
                    t_wdata = {lo_reg, j_dec[AW-1:0]};
                    sp_next = sp_reg + ONE_C;
                end
            end
            ST_EMIT_RD:
            begin
                s_re    = 1'b1;
                s_raddr = k_reg[AW-1:0];
            end
            ST_EMIT_LD:
            begin
                emit.load              = 1'b1;
                emit.data.sorted_value = s_rdata;
                emit.data.end_of_run   = (k_reg + ONE_C == count_reg);
                emit.data.overflow     = dropped_reg;
                k_next                 = k_reg + ONE_C;
            end
            ST_EMIT_WAIT:
            begin
                if (taken)
                begin
                    if (k_reg == count_reg)
                    begin
                        count_next   = '0;
                        dropped_next = 1'b0;
                    end
                    else
                    begin
                        s_re    = 1'b1;
                        s_raddr = k_reg[AW-1:0];
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

endmodule

/* rtl/qsort_checker.sv */
// Port-level checks for the quicksort sorter and the bind that attaches them.
// Depends on qsort_pkg and quicksort_sorter_top.
module qsort_checker
    import qsort_pkg::*;
(
    input logic    clk,
    input logic    rst_n,
    input logic    item_valid,
    input logic    item_stall,
    input item_t   item,
    input logic    result_valid,
    input logic    result_stall,
    input result_t result
);

    // a stalled result holds
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(result))
        else $error("stalled result changed or dropped");

    // no new input while a run is being read out
    a_no_input_during_output: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> item_stall)
        else $error("input open while results pending");

    // the last transaction closes the input side
    a_last_stalls: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && !item_stall && item.last |=> item_stall)
        else $error("input not stalled after last");

    // nothing follows the end of a run directly
    a_run_end: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_stall && result.end_of_run |=> !result_valid)
        else $error("result after end of run");

endmodule

bind quicksort_sorter_top qsort_checker u_qsort_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
);
